/* design/pfsa_pkg.sv */
package pfsa_pkg;

    localparam int FRAME_W = 52;
    localparam int SLOT_W  = 13;

    typedef enum logic
    {
        OP_FREE  = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_STATIC  = 3'd0,
        ST_DYNAMIC = 3'd1,
        ST_STORAGE = 3'd2,
        ST_ALLOC   = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic
    {
        S_IDLE,
        S_RESP
    } state_t;

    // one access per cycle: write or read at the shared address
    typedef struct packed
    {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

/* design/pfsa_if.sv */
interface pfsa_in_if
    import pfsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [FRAME_W-1:0] page_frame;

    modport source (output valid, output op, output page_frame, input ready);
    modport sink (input valid, input op, input page_frame, output ready);
    modport monitor (input valid, input ready, input op, input page_frame);
endinterface

interface pfsa_out_if
    import pfsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic [SLOT_W-1:0]  storage_slot;

    modport source (output valid, output status, output frame_out, output storage_slot,
                    input ready);
    modport sink (input valid, input status, input frame_out, input storage_slot,
                  output ready);
    modport monitor (input valid, input ready, input status, input frame_out,
                     input storage_slot);
endinterface

/* design/page_frame_stack_allocator.sv */
// Two-tier LIFO free list of physical page frames. Each request transaction
// frees (op 0) or allocates (op 1) one frame and yields exactly one response
// transaction. Frees fill a small static stack first, then a dynamic stack;
// when the dynamic stack has no backed room, the freed frame is reported as
// new backing storage (status 2, with the entry index where its entries begin)
// and room grows by ENTRIES_PER_PAGE entries, capped at DYNAMIC_DEPTH. Allocs
// pop the static stack first, then the dynamic one; allocating from empty
// reports status 4, and a free past DYNAMIC_DEPTH reports status 5 and drops
// the frame. Each transaction makes a single access to the static or dynamic
// stack memory (synchronous read) when the request is taken, then moves the
// result into the output register. The output register lets the next
// request be taken while a response waits. No clearing pass after reset.
module page_frame_stack_allocator
    import pfsa_pkg::*;
#(
    parameter int STATIC_DEPTH     = 16,
    parameter int DYNAMIC_DEPTH    = 4096,
    parameter int ENTRIES_PER_PAGE = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    pfsa_in_if.sink    req,
    pfsa_out_if.source rsp
);

    localparam int SA = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
    localparam int DA = $clog2(DYNAMIC_DEPTH);

    mem_ctl_t           s_ctl;
    mem_ctl_t           d_ctl;
    logic [SA-1:0]      s_addr;
    logic [DA-1:0]      d_addr;
    logic [FRAME_W-1:0] wdata;
    logic [FRAME_W-1:0] s_rdata;
    logic [FRAME_W-1:0] d_rdata;

    pfsa_ctrl #(
        .STATIC_DEPTH     (STATIC_DEPTH),
        .DYNAMIC_DEPTH    (DYNAMIC_DEPTH),
        .ENTRIES_PER_PAGE (ENTRIES_PER_PAGE)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .s_ctl   (s_ctl),
        .s_addr  (s_addr),
        .d_ctl   (d_ctl),
        .d_addr  (d_addr),
        .wdata   (wdata),
        .s_rdata (s_rdata),
        .d_rdata (d_rdata)
    );

    pfsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STATIC_DEPTH)
    ) u_static_ram (
        .clk   (clk),
        .ctl   (s_ctl),
        .addr  (s_addr),
        .wdata (wdata),
        .rdata (s_rdata)
    );

    pfsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DYNAMIC_DEPTH)
    ) u_dynamic_ram (
        .clk   (clk),
        .ctl   (d_ctl),
        .addr  (d_addr),
        .wdata (wdata),
        .rdata (d_rdata)
    );

endmodule

/* design/pfsa_ram.sv */
module pfsa_ram
    import pfsa_pkg::*;
#(
    parameter int WIDTH = 52,
    parameter int DEPTH = 16
)
(
    input  logic                                        clk,
    input  mem_ctl_t                                    ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pfsa_ctrl.sv */
module pfsa_ctrl
    import pfsa_pkg::*;
#(
    parameter int STATIC_DEPTH     = 16,
    parameter int DYNAMIC_DEPTH    = 4096,
    parameter int ENTRIES_PER_PAGE = 512
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    pfsa_in_if.sink                    req,
    pfsa_out_if.source                 rsp,
    output mem_ctl_t                   s_ctl,
    output logic [((STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1)-1:0] s_addr,
    output mem_ctl_t                   d_ctl,
    output logic [$clog2(DYNAMIC_DEPTH)-1:0] d_addr,
    output logic [FRAME_W-1:0]         wdata,
    input  logic [FRAME_W-1:0]         s_rdata,
    input  logic [FRAME_W-1:0]         d_rdata
);

    localparam int SA = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
    localparam int SRW = $clog2(STATIC_DEPTH + 1);
    localparam int DA = $clog2(DYNAMIC_DEPTH);
    localparam int CW = $clog2(DYNAMIC_DEPTH + 1);
    localparam int GROW_MAX =
        (ENTRIES_PER_PAGE > DYNAMIC_DEPTH) ? DYNAMIC_DEPTH : ENTRIES_PER_PAGE;

    state_t state_reg, state_next;

    logic [SRW-1:0] static_room_reg, static_room_next;
    logic [CW-1:0]  dyn_count_reg, dyn_count_next;
    logic [CW-1:0]  dyn_room_reg, dyn_room_next;

    status_t            pend_status_reg;
    logic [FRAME_W-1:0] pend_frame_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic               pend_static_reg;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    logic               accept;
    logic               load_out;
    status_t            dec_status;
    logic [FRAME_W-1:0] dec_frame;
    logic [SLOT_W-1:0]  dec_slot;
    logic               dec_static;
    logic [CW-1:0]      space;
    logic [CW-1:0]      grow;

    assign accept = req.valid && req.ready;
    assign space  = CW'(DYNAMIC_DEPTH) - dyn_count_reg;
    assign grow   = (space > CW'(GROW_MAX)) ? CW'(GROW_MAX) : space;
    assign wdata  = req.page_frame;

    // decode the transaction against the current counters
    always_comb
    begin
        dec_status       = ST_EMPTY;
        dec_frame        = '0;
        dec_slot         = '0;
        dec_static       = 1'b0;
        static_room_next = static_room_reg;
        dyn_count_next   = dyn_count_reg;
        dyn_room_next    = dyn_room_reg;
        s_ctl            = '0;
        d_ctl            = '0;
        s_addr           = SA'(static_room_reg);
        d_addr           = DA'(dyn_count_reg);

        if (req.op == OP_FREE)
        begin
            if (static_room_reg != '0)
            begin
                dec_status       = ST_STATIC;
                s_ctl.we         = accept;
                s_addr           = SA'(static_room_reg - SRW'(1));
                static_room_next = static_room_reg - SRW'(1);
            end
            else if (dyn_room_reg == '0)
            begin
                if (dyn_count_reg >= CW'(DYNAMIC_DEPTH))
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    // the freed page itself backs the next run of entries
                    dec_status    = ST_STORAGE;
                    dec_frame     = req.page_frame;
                    dec_slot      = SLOT_W'(dyn_count_reg);
                    dyn_room_next = grow;
                end
            end
            else if (dyn_count_reg < CW'(DYNAMIC_DEPTH))
            begin
                dec_status     = ST_DYNAMIC;
                d_ctl.we       = accept;
                d_addr         = DA'(dyn_count_reg);
                dyn_count_next = dyn_count_reg + CW'(1);
                dyn_room_next  = dyn_room_reg - CW'(1);
            end
            else
            begin
                dec_status = ST_FULL;
            end
        end
        else
        begin
            if (static_room_reg != SRW'(STATIC_DEPTH))
            begin
                dec_status       = ST_ALLOC;
                dec_static       = 1'b1;
                s_ctl.re         = accept;
                s_addr           = SA'(static_room_reg);
                static_room_next = static_room_reg + SRW'(1);
            end
            else if (dyn_count_reg != '0)
            begin
                dec_status     = ST_ALLOC;
                d_ctl.re       = accept;
                d_addr         = DA'(dyn_count_reg - CW'(1));
                dyn_count_next = dyn_count_reg - CW'(1);
                dyn_room_next  = dyn_room_reg + CW'(1);
            end
            else
            begin
                dec_status = ST_EMPTY;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_RESP:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            static_room_reg <= SRW'(STATIC_DEPTH);
            dyn_count_reg   <= '0;
            dyn_room_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                static_room_reg <= static_room_next;
                dyn_count_reg   <= dyn_count_next;
                dyn_room_reg    <= dyn_room_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= dec_status;
            pend_frame_reg  <= dec_frame;
            pend_slot_reg   <= dec_slot;
            pend_static_reg <= dec_static;
        end
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_slot_reg   <= pend_slot_reg;
            // read data is held by the memory until the next read
            if (pend_status_reg == ST_ALLOC)
            begin
                out_frame_reg <= pend_static_reg ? s_rdata : d_rdata;
            end
            else
            begin
                out_frame_reg <= pend_frame_reg;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.frame_out    = out_frame_reg;
    assign rsp.storage_slot = out_slot_reg;

endmodule

/* design/pfsa_checker.sv */
module pfsa_checker
    import pfsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    pfsa_in_if.sink    req,
    pfsa_out_if.source rsp
);

    // a response held back must stay offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
        else $error("response dropped while stalled");

    // one transaction in flight: no request taken in the cycle after one
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken back to back");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_ALLOC && rsp.status != ST_STORAGE
        |-> rsp.frame_out == '0)
        else $error("frame_out not zero for this status");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_STORAGE |-> rsp.storage_slot == '0)
        else $error("storage_slot not zero for this status");

endmodule

bind page_frame_stack_allocator pfsa_checker u_pfsa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
